// File: rtl/ktlru_pkg.sv
// Shared types, widths and constants for the keyed station table.
package ktlru_pkg;

    // Default table size.
    localparam int TABLE_ENTRIES_DEFAULT = 128;

    // Field widths of the input word.
    localparam int KEY_W     = 56;
    localparam int FLIGHT_W  = 48;
    localparam int LABEL_W   = 16;
    localparam int CHANNEL_W = 18;
    localparam int TIME_W    = 48;

    // Field widths of the result word.
    localparam int SLOT_W  = 7;
    localparam int TOTAL_W = 32;
    localparam int USED_W  = 8;

    // Input word layout, lowest field first.
    localparam int KEY_LSB     = 0;
    localparam int FLIGHT_LSB  = KEY_LSB + KEY_W;
    localparam int LABEL_LSB   = FLIGHT_LSB + FLIGHT_W;
    localparam int CHANNEL_LSB = LABEL_LSB + LABEL_W;
    localparam int TIME_LSB    = CHANNEL_LSB + CHANNEL_W;
    localparam int S_FIELDS_W  = TIME_LSB + TIME_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Result word layout, lowest field first.
    localparam int M_FIELDS_W = SLOT_W + 1 + 1 + TOTAL_W + USED_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    // Request kinds carried in s_tuser.
    localparam logic REQ_NOTE  = 1'b0;
    localparam logic REQ_CLEAR = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_ALLOC,
        ST_ENTRY_RD,
        ST_COMMIT
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic clear_all;
        logic scan_step;
        logic take_hit;
        logic alloc;
        logic commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_clear;
        logic key_zero;
        logic table_empty;
        logic key_hit;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

// File: rtl/ktlru_ctrl.sv
// Sequencing state machine for the keyed station table.
module ktlru_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  ktlru_pkg::dp_status_t  status,
    output ktlru_pkg::ctrl_cmd_t   cmd
);
    import ktlru_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    if (status.req_clear) begin
                        cmd.clear_all = 1'b1;
                    end else if (status.key_zero) begin
                        state_next = ST_IDLE;
                    end else if (status.table_empty) begin
                        state_next = ST_ALLOC;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (status.key_hit) begin
                    cmd.take_hit = 1'b1;
                    state_next   = ST_ENTRY_RD;
                end else begin
                    cmd.scan_step = 1'b1;
                    state_next    = status.scan_last ? ST_ALLOC : ST_SCAN_RD;
                end
            end
            ST_ALLOC: begin
                cmd.alloc  = 1'b1;
                state_next = ST_ENTRY_RD;
            end
            ST_ENTRY_RD: begin
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/ktlru_dp.sv
// Datapath of the keyed station table: entry memories, scan, allocation and result register.
module ktlru_dp #(
    parameter int TABLE_ENTRIES = ktlru_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  ktlru_pkg::ctrl_cmd_t             cmd,
    output ktlru_pkg::dp_status_t            status,
    input  logic [ktlru_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    output logic [ktlru_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                             m_tready
);
    import ktlru_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int INFO_W = TOTAL_W + FLIGHT_W + LABEL_W + CHANNEL_W;
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TABLE_ENTRIES);

    // Entry memories: keys and times are scanned, the rest is read per entry.
    logic [KEY_W-1:0]  key_mem  [TABLE_ENTRIES];
    logic [TIME_W-1:0] time_mem [TABLE_ENTRIES];
    logic [INFO_W-1:0] info_mem [TABLE_ENTRIES];

    logic [KEY_W-1:0]     in_key;
    logic [KEY_W-1:0]     key_reg;
    logic [FLIGHT_W-1:0]  flight_reg;
    logic [LABEL_W-1:0]   label_reg;
    logic [CHANNEL_W-1:0] chan_reg;
    logic [TIME_W-1:0]    time_reg;

    logic [IDX_W-1:0]  idx_reg,  idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic [IDX_W-1:0]  min_idx_reg;
    logic [TIME_W-1:0] min_time_reg;
    logic              new_reg,   new_next;
    logic              evict_reg, evict_next;
    logic [CNT_W-1:0]  occ_reg,   occ_next;

    logic [KEY_W-1:0]  key_rd_reg;
    logic [TIME_W-1:0] time_rd_reg;
    logic [INFO_W-1:0] info_rd_reg;

    logic                 m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    logic [INFO_W-1:0]    info_old;
    logic [TOTAL_W-1:0]   count_old,  count_new;
    logic [FLIGHT_W-1:0]  flight_old, flight_new;
    logic [LABEL_W-1:0]   label_old,  label_new;
    logic [INFO_W-1:0]    info_new;
    logic                 take_min;

    assign in_key = s_tdata[KEY_LSB +: KEY_W];

    // Status towards the controller.
    always_comb begin
        status.req_clear   = (s_tuser == REQ_CLEAR);
        status.key_zero    = (in_key == '0);
        status.table_empty = (occ_reg == '0);
        status.key_hit     = (key_rd_reg == key_reg);
        status.scan_last   = ((CNT_W'(idx_reg) + CNT_W'(1)) == occ_reg);
        status.out_free    = !m_valid_reg || m_tready;
    end

    // Request fields are held for the whole operation.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            key_reg    <= in_key;
            flight_reg <= s_tdata[FLIGHT_LSB +: FLIGHT_W];
            label_reg  <= s_tdata[LABEL_LSB +: LABEL_W];
            chan_reg   <= s_tdata[CHANNEL_LSB +: CHANNEL_W];
            time_reg   <= s_tdata[TIME_LSB +: TIME_W];
        end
    end

    // Oldest entry seen so far; strict compare keeps the lowest index on ties.
    assign take_min = (idx_reg == '0) || (time_rd_reg < min_time_reg);

    always_ff @(posedge aclk) begin
        if (cmd.scan_step && take_min) begin
            min_idx_reg  <= idx_reg;
            min_time_reg <= time_rd_reg;
        end
    end

    // Scan index, chosen slot, flags and fill count.
    always_comb begin
        idx_next   = idx_reg;
        slot_next  = slot_reg;
        new_next   = new_reg;
        evict_next = evict_reg;
        occ_next   = occ_reg;
        if (cmd.capture) begin
            idx_next = '0;
        end
        if (cmd.clear_all) begin
            occ_next = '0;
        end
        if (cmd.scan_step) begin
            idx_next = idx_reg + IDX_W'(1);
        end
        if (cmd.take_hit) begin
            slot_next  = idx_reg;
            new_next   = 1'b0;
            evict_next = 1'b0;
        end
        if (cmd.alloc) begin
            new_next = 1'b1;
            if (occ_reg != FULL_COUNT) begin
                slot_next  = occ_reg[IDX_W-1:0];
                occ_next   = occ_reg + CNT_W'(1);
                evict_next = 1'b0;
            end else begin
                slot_next  = min_idx_reg;
                evict_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg   <= idx_next;
        slot_reg  <= slot_next;
        new_reg   <= new_next;
        evict_reg <= evict_next;
    end

    // Merge the request into the entry; a new entry starts from zero.
    always_comb begin
        info_old   = new_reg ? '0 : info_rd_reg;
        count_old  = info_old[INFO_W-1 -: TOTAL_W];
        flight_old = info_old[LABEL_W + CHANNEL_W +: FLIGHT_W];
        label_old  = info_old[CHANNEL_W +: LABEL_W];
        count_new  = (count_old == '1) ? count_old : count_old + TOTAL_W'(1);
        flight_new = (flight_reg != '0) ? flight_reg : flight_old;
        label_new  = (label_reg != '0) ? label_reg : label_old;
        info_new   = {count_new, flight_new, label_new, chan_reg};
    end

    // Memory ports: registered reads every cycle, writes on commit.
    always_ff @(posedge aclk) begin
        key_rd_reg  <= key_mem[idx_reg];
        time_rd_reg <= time_mem[idx_reg];
        info_rd_reg <= info_mem[slot_reg];
        if (cmd.commit) begin
            if (new_reg) begin
                key_mem[slot_reg] <= key_reg;
            end
            time_mem[slot_reg] <= time_reg;
            info_mem[slot_reg] <= info_new;
        end
    end

    // Result register; the channel is overwritten by every update.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_data_reg <= M_TDATA_W'({USED_W'(occ_reg), count_new, evict_reg, new_reg,
                                      SLOT_W'(slot_reg)});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: rtl/keyed_table_lru_replace.sv
// Top level of the keyed station table with least-recently-heard replacement.
//
//  Channel | Direction | Ports                         | Word
//  --------+-----------+-------------------------------+-------------------------------------
//  s_      | in        | s_tvalid s_tready s_tdata     | request: key, flight, label,
//          |           | s_tuser                       | channel, time; tuser = request kind
//  m_      | out       | m_tvalid m_tready m_tdata     | slot, new, evicted, total, used
//
// A note request is captured, then each occupied entry is read and checked in
// turn for its key through the single read port of the key and time memories;
// allocation on a miss, entry read and write-back follow. Clear and zero-key
// requests end in the capture state and give no result word.
// Reset empties the table at once; entry memories are not cleared.
// A stalled result is held in the output register; the next request is accepted
// meanwhile and waits at write-back until the result has been taken.
module keyed_table_lru_replace #(
    parameter int TABLE_ENTRIES = ktlru_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata from bit 0: station_key, flight_code, label_code, channel_khz, heard_time
    input  logic [ktlru_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: req_type
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata from bit 0: slot_index, was_new, was_evicted, message_total, entries_used
    output logic [ktlru_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ktlru_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;

    // Sequencer.
    ktlru_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // Table storage and result.
    ktlru_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tready (m_tready)
    );

endmodule

// File: rtl/ktlru_checker.sv
// Port-level checks for the keyed station table, bound to the top level.
module ktlru_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [ktlru_pkg::M_TDATA_W-1:0]  m_tdata
);
    import ktlru_pkg::*;

    // No result word straight after reset.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // A stalled result word holds.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

    // Replacing an entry always makes a new one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[SLOT_W + 1] |-> m_tdata[SLOT_W])
        else $error("eviction reported without a new entry");

    // Every reported entry has counted at least this message.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[SLOT_W + 2 +: TOTAL_W] != '0)
        else $error("message total of zero reported");

endmodule

bind keyed_table_lru_replace ktlru_checker u_ktlru_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: dv/keyed_table_lru_replace_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the keyed station table with least-recently-heard replacement.
module keyed_table_lru_replace_tb;
    import ktlru_pkg::*;

    localparam int ENTRIES           = TABLE_ENTRIES_DEFAULT;
    localparam int MAX_GAP           = 12;
    localparam int SETTLE_CYCLES     = 2 * ENTRIES + 40;
    localparam int WATCHDOG_LIMIT    = 3000;
    localparam int ERROR_PRINT_LIMIT = 100;
    localparam int RANDOM_ITEMS      = 1200;
    localparam int POOL_SIZE         = 180;

    // Request word as it sits in s_tdata, lowest field last in the declaration.
    typedef struct packed {
        logic [TIME_W-1:0]    heard_time;
        logic [CHANNEL_W-1:0] channel_khz;
        logic [LABEL_W-1:0]   label_code;
        logic [FLIGHT_W-1:0]  flight_code;
        logic [KEY_W-1:0]     station_key;
    } note_word_t;

    // Result word as it sits in m_tdata.
    typedef struct packed {
        logic [USED_W-1:0]  entries_used;
        logic [TOTAL_W-1:0] message_total;
        logic               was_evicted;
        logic               was_new;
        logic [SLOT_W-1:0]  slot_index;
    } slot_report_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // s_tdata from bit 0: station_key, flight_code, label_code, channel_khz, heard_time
    logic [S_TDATA_W-1:0] s_tdata;
    // s_tuser: req_type
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // m_tdata from bit 0: slot_index, was_new, was_evicted, message_total, entries_used
    logic [M_TDATA_W-1:0] m_tdata;

    // Predicted contents of the station table.
    logic [KEY_W-1:0]     stn_key     [ENTRIES];
    logic [FLIGHT_W-1:0]  stn_flight  [ENTRIES];
    logic [LABEL_W-1:0]   stn_label   [ENTRIES];
    logic [CHANNEL_W-1:0] stn_khz     [ENTRIES];
    logic [TIME_W-1:0]    stn_heard   [ENTRIES];
    logic [TOTAL_W-1:0]   stn_count   [ENTRIES];
    int                   stn_used;

    slot_report_t         due_reports[$];
    int                   mismatch_count = 0;
    bit                   source_idles;
    bit                   sink_idles;

    keyed_table_lru_replace #(
        .TABLE_ENTRIES(ENTRIES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    // Free-running clock.
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Apply one accepted request to the predicted table and queue the report it yields.
    task automatic update_station_table(input logic kind, input note_word_t word);
        int           slot;
        bit           found;
        slot_report_t report;
        slot  = 0;
        found = 1'b0;
        report = '0;
        if (kind == REQ_CLEAR) begin
            stn_used = 0;
            return;
        end
        if (word.station_key == '0) return;

        // Look the key up among the occupied entries only.
        for (int i = 0; i < stn_used; i++) begin
            if (!found && stn_key[i] == word.station_key) begin
                slot  = i;
                found = 1'b1;
            end
        end

        if (!found) begin
            if (stn_used < ENTRIES) begin
                slot = stn_used;
                stn_used++;
            end else begin
                // Oldest time wins; the strict compare keeps the lowest index on a tie.
                slot = 0;
                for (int i = 1; i < ENTRIES; i++)
                    if (stn_heard[i] < stn_heard[slot]) slot = i;
                report.was_evicted = 1'b1;
            end
            stn_key[slot]    = word.station_key;
            stn_flight[slot] = '0;
            stn_label[slot]  = '0;
            stn_khz[slot]    = '0;
            stn_heard[slot]  = '0;
            stn_count[slot]  = '0;
        end

        // Flight and label are kept when the request carries zero.
        if (word.flight_code != '0) stn_flight[slot] = word.flight_code;
        if (word.label_code != '0) stn_label[slot] = word.label_code;
        stn_khz[slot]   = word.channel_khz;
        stn_heard[slot] = word.heard_time;
        if (stn_count[slot] != '1) stn_count[slot]++;

        report.slot_index    = SLOT_W'(slot);
        report.was_new       = !found;
        report.message_total = stn_count[slot];
        report.entries_used  = USED_W'(stn_used);
        due_reports.push_back(report);
    endtask

    // Offer one request word, wait for the handshake, then predict its outcome.
    // Valid is left high after acceptance; the next call or a hold-off lowers it.
    task automatic send_request(input logic kind, input note_word_t word);
        int gap;
        gap = source_idles ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= S_TDATA_W'(word);
        do @(posedge aclk); while (!s_tready);
        update_station_table(kind, word);
    endtask

    // Stop offering words until every predicted report has been seen.
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_reports.size() != 0) @(posedge aclk);
    endtask

    // A callsign of one to seven characters, first character in the top byte.
    function automatic logic [KEY_W-1:0] make_callsign();
        logic [KEY_W-1:0] key;
        int               len;
        len = $urandom_range(1, 7);
        key = '0;
        for (int i = 0; i < 7; i++)
            key = {key[KEY_W-9:0], (i < len) ? 8'($urandom_range(8'h30, 8'h5A)) : 8'h00};
        return key;
    endfunction

    // Random payload around a given key and time stamp; zero flight and label are common.
    function automatic note_word_t random_word(input logic [KEY_W-1:0] key,
                                               input logic [TIME_W-1:0] stamp);
        note_word_t word;
        word.station_key = key;
        word.flight_code = ($urandom_range(0, 9) < 3) ? '0 : FLIGHT_W'({$urandom(), $urandom()});
        word.label_code  = ($urandom_range(0, 9) < 3) ? '0 : LABEL_W'($urandom());
        word.channel_khz = ($urandom_range(0, 9) == 0) ? '0 : CHANNEL_W'($urandom());
        word.heard_time  = stamp;
        return word;
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] seen);
        if (seen !== want) begin
            mismatch_count++;
            if (mismatch_count <= ERROR_PRINT_LIMIT)
                $error("%s: expected %0d, actual %0d", name, want, seen);
        end
    endfunction

    // All-ones and all-zero fields, the smallest key and a hit on an existing key.
    task automatic test_field_extremes();
        note_word_t word;
        word = '1;
        send_request(REQ_NOTE, word);
        word = '0;
        word.station_key = '1;
        send_request(REQ_NOTE, word);
        word = '0;
        word.station_key = KEY_W'(1);
        word.heard_time  = TIME_W'(1);
        send_request(REQ_NOTE, word);
        send_request(REQ_NOTE, random_word(make_callsign(), TIME_W'(2)));
    endtask

    // Zero keys and clears give no report; a clear restarts allocation at entry 0.
    task automatic test_ignored_requests();
        note_word_t word;
        word = '1;
        word.station_key = '0;
        send_request(REQ_NOTE, word);
        word = '1;
        send_request(REQ_CLEAR, word);
        word = '0;
        word.station_key = KEY_W'(1);
        send_request(REQ_NOTE, word);
        send_request(REQ_NOTE, word);
        word = '0;
        send_request(REQ_CLEAR, word);
        word = '1;
        send_request(REQ_NOTE, word);
        word.station_key = '0;
        send_request(REQ_NOTE, word);
    endtask

    // Fill every entry with one shared time stamp, then force replacements.
    task automatic test_fill_and_evict();
        note_word_t       word;
        logic [KEY_W-1:0] fill_keys[ENTRIES];
        word = '0;
        send_request(REQ_CLEAR, word);
        for (int i = 0; i < ENTRIES; i++) begin
            fill_keys[i] = {24'h46494C, 32'(i)};
            send_request(REQ_NOTE, random_word(fill_keys[i], TIME_W'(1000)));
        end
        // Equal oldest times: entries 0 and 1 go first.
        send_request(REQ_NOTE, random_word({24'h4E4557, 32'(0)}, TIME_W'(2000)));
        send_request(REQ_NOTE, random_word({24'h4E4557, 32'(1)}, TIME_W'(2001)));
        // Entry 2 is heard again, so the oldest moves on to entry 3.
        send_request(REQ_NOTE, random_word(fill_keys[2], TIME_W'(2002)));
        send_request(REQ_NOTE, random_word({24'h4E4557, 32'(2)}, TIME_W'(2003)));
        // A key that was pushed out comes back as a new entry.
        send_request(REQ_NOTE, random_word(fill_keys[0], TIME_W'(2004)));
    endtask

    // Mostly callsigns from a pool slightly larger than the table, with noise mixed in.
    task automatic test_random_traffic();
        logic [KEY_W-1:0]  key_pool[POOL_SIZE];
        logic [TIME_W-1:0] clock_us;
        note_word_t        word;
        logic              kind;
        int                pick;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = make_callsign();
        clock_us = TIME_W'(5000);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // Idling changes every hundred words, sometimes off on one or both sides.
            if (n % 100 == 0) begin
                source_idles = $urandom_range(0, 2) != 0;
                sink_idles   = $urandom_range(0, 2) != 0;
            end
            if (n == RANDOM_ITEMS / 2) drain_reports();

            // Time usually moves on; an unchanged stamp now and then makes ties.
            if ($urandom_range(0, 19) != 0) clock_us += TIME_W'($urandom_range(1, 2000000));

            kind = REQ_NOTE;
            pick = $urandom_range(0, 999);
            if (pick < 4) begin
                kind = REQ_CLEAR;
                word = random_word(KEY_W'({$urandom(), $urandom()}), clock_us);
            end else if (pick < 40) begin
                word = random_word('0, clock_us);
            end else if (pick < 110) begin
                word = random_word(KEY_W'({$urandom(), $urandom()}), clock_us);
            end else begin
                word = random_word(key_pool[$urandom_range(0, POOL_SIZE - 1)], clock_us);
            end
            if ($urandom_range(0, 19) == 0) word.heard_time = TIME_W'({$urandom(), $urandom()});
            send_request(kind, word);
        end
    endtask

    // Compare every accepted result word with the oldest prediction.
    initial begin : report_checker
        int           hold;
        slot_report_t seen;
        slot_report_t want;
        hold     = 0;
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                seen = slot_report_t'(m_tdata[M_FIELDS_W-1:0]);
                if (due_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= ERROR_PRINT_LIMIT)
                        $error("result word with no request outstanding: %h", m_tdata);
                end else begin
                    want = due_reports.pop_front();
                    compare_field("slot_index", 64'(want.slot_index), 64'(seen.slot_index));
                    compare_field("was_new", 64'(want.was_new), 64'(seen.was_new));
                    compare_field("was_evicted", 64'(want.was_evicted),
                                  64'(seen.was_evicted));
                    compare_field("message_total", 64'(want.message_total),
                                  64'(seen.message_total));
                    compare_field("entries_used", 64'(want.entries_used),
                                  64'(seen.entries_used));
                end
                hold = sink_idles ? $urandom_range(0, MAX_GAP) : 0;
            end else if (hold > 0) begin
                hold--;
            end
            m_tready <= (hold == 0);
        end
    end

    // End the run if no word moves on either side for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("keyed_table_lru_replace regression: fail");
        $finish;
    end

    // Reset, run the tests in turn, then wait for the last reports.
    initial begin : stimulus
        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tuser      = REQ_NOTE;
        s_tdata      = '0;
        source_idles = 1'b1;
        sink_idles   = 1'b1;
        stn_used     = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            stn_key[i]    = '0;
            stn_flight[i] = '0;
            stn_label[i]  = '0;
            stn_khz[i]    = '0;
            stn_heard[i]  = '0;
            stn_count[i]  = '0;
        end
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_field_extremes();
        test_ignored_requests();
        test_fill_and_evict();
        test_random_traffic();

        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("keyed_table_lru_replace regression: pass");
        end else begin
            $display("keyed_table_lru_replace regression: fail");
        end
        $finish;
    end

endmodule
